[rtl/isl_pkg.sv]
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants
// Word layout, command codes and register indexes of the spectrum lookup.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_DISTANCE_AU   = 1'b0;
  localparam logic REG_TABLE_ENTRIES = 1'b1;

  localparam logic [31:0] DIST_ONE = 32'h0100_0000;
  localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  entry_index;
    logic [31:0] entry_wavelength;
    logic [31:0] entry_irradiance;
    logic [31:0] query_wavelength;
  } item_t;

endpackage

[rtl/isl_if.sv]
// ----------------------------------------------------------------------------
// isl_item_if, isl_result_if: valid/ready channels
// Input words and result words of the spectrum lookup.
// ----------------------------------------------------------------------------
interface isl_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [9:0]  entry_index;
  logic [31:0] entry_wavelength;
  logic [31:0] entry_irradiance;
  logic [31:0] query_wavelength;
  modport source(output valid, cmd, entry_index, entry_wavelength, entry_irradiance,
                 query_wavelength, input ready);
  modport sink(input valid, cmd, entry_index, entry_wavelength, entry_irradiance,
               query_wavelength, output ready);
endinterface

interface isl_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] irradiance_out;
  logic        valid_res;
  modport source(output valid, irradiance_out, valid_res, input ready);
  modport sink(input valid, irradiance_out, valid_res, output ready);
endinterface

[rtl/interpolated_spectrum_lookup.sv]
// ----------------------------------------------------------------------------
// interpolated_spectrum_lookup: table lookup with linear interpolation
// Loads wavelength/irradiance pairs and answers irradiance queries scaled by
// the inverse square of the sun distance.
// ----------------------------------------------------------------------------
// channel   direction  handshake     payload
// items     in         valid/ready   cmd, entry_*, query_wavelength
// results   out        valid/ready   irradiance_out, valid_res
// cfg       in         cfg_write     cfg_index, cfg_data
//
// A load word is written while the sequencer is idle; a query is paced by the
// search probe on the single table read port and by the one-bit-per-cycle
// shared divider.
// Reset is synchronous; the table content is undefined until written.
// Two input words queue ahead of the sequencer; a held result stalls only the
// next query at its final step.
// ----------------------------------------------------------------------------
module interpolated_spectrum_lookup
  import isl_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  isl_item_if.sink     items,
  isl_result_if.source results,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] distance_au;
  logic [10:0] table_entries;
  item_t       head;
  logic        head_valid;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_au   <= DIST_ONE;
      table_entries <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DISTANCE_AU:   distance_au   <= cfg_data;
        REG_TABLE_ENTRIES: table_entries <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  isl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  isl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .distance_au   (distance_au),
    .table_entries (table_entries),
    .results       (results)
  );
endmodule

[rtl/isl_ram.sv]
// ----------------------------------------------------------------------------
// isl_ram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module isl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/isl_front.sv]
// ----------------------------------------------------------------------------
// isl_front: input queue
// Accepts words and holds them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module isl_front
  import isl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  isl_item_if.sink   items,
  output item_t      head,
  output logic       head_valid,
  input  logic       pop
);
  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  assign items.ready = (count != 2'd2);
  assign push        = items.valid && items.ready;
  assign head_valid  = (count != 2'd0);
  assign take        = pop && head_valid;
  assign head        = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{items.cmd, items.entry_index, items.entry_wavelength,
                        items.entry_irradiance, items.query_wavelength};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end
endmodule

[rtl/isl_back.sv]
// ----------------------------------------------------------------------------
// isl_back: lookup sequencer
// Writes table entries, runs the binary search, interpolates and scales by
// the inverse square of the distance with a shared serial divider.
// ----------------------------------------------------------------------------
module isl_back
  import isl_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       head,
  input  logic        head_valid,
  output logic        pop,
  input  logic [31:0] distance_au,
  input  logic [10:0] table_entries,
  isl_result_if.source results
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RDN  = 4'd2;
  localparam logic [3:0] S_MID  = 4'd3;
  localparam logic [3:0] S_MIDW = 4'd4;
  localparam logic [3:0] S_INTP = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_PREP = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_SMUL = 4'd9;
  localparam logic [3:0] S_SCHK = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]    state;
  logic [CW-1:0] n_eff;
  logic [AW-1:0] lo, hi, mid, mid_r, raddr;
  logic [31:0]   q, x_lo, x_hi, y_lo, y_hi, y, diff, num, dx, quo, quo_next, sh;
  logic [31:0]   mul_a, mul_b, res;
  logic [63:0]   product, prod, rem, dvs;
  logic [64:0]   r2;
  logic          ge, up, scale, res_val, we;
  logic [4:0]    cnt;
  logic [63:0]   rdata;
  logic [31:0]   rd_wl, rd_irr;

  assign n_eff = ({21'd0, table_entries} > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                              : CW'(table_entries);
  assign mid   = AW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign rd_wl  = rdata[63:32];
  assign rd_irr = rdata[31:0];
  assign pop   = (state == S_IDLE) && head_valid;
  assign we    = pop && (head.cmd == CMD_LOAD) && (32'(head.entry_index) < TABLE_DEPTH);

  always_comb begin
    case (state)
      S_RD0:   raddr = AW'(n_eff - 1'b1);
      S_MID:   raddr = mid;
      default: raddr = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_MUL: begin
        mul_a = diff;
        mul_b = num;
      end
      default: begin
        mul_a = distance_au;
        mul_b = distance_au;
      end
    endcase
  end
  assign product = mul_a * mul_b;

  assign r2       = {rem, sh[31]};
  assign ge       = r2 >= {1'b0, dvs};
  assign quo_next = {quo[30:0], ge};

  isl_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(head.entry_index)),
    .wdata ({head.entry_wavelength, head.entry_irradiance}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      results.valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!results.valid || results.ready)) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid && head.cmd == CMD_QUERY) begin
            q <= head.query_wavelength;
            if (n_eff == '0) begin
              res     <= '0;
              res_val <= 1'b0;
              state   <= S_OUT;
            end else begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: begin
          x_lo <= rd_wl;
          y_lo <= rd_irr;
          if (q < rd_wl) begin
            res     <= '0;
            res_val <= 1'b0;
            state   <= S_OUT;
          end else begin
            state <= S_RDN;
          end
        end
        S_RDN: begin
          x_hi <= rd_wl;
          y_hi <= rd_irr;
          lo   <= '0;
          hi   <= AW'(n_eff - 1'b1);
          if (q > rd_wl) begin
            res     <= '0;
            res_val <= 1'b0;
            state   <= S_OUT;
          end else begin
            state <= S_MID;
          end
        end
        S_MID: begin
          mid_r <= mid;
          if ({1'b0, hi} > {1'b0, lo} + 1'b1) begin
            state <= S_MIDW;
          end else begin
            state <= S_INTP;
          end
        end
        S_MIDW: begin
          if (rd_wl <= q) begin
            lo   <= mid_r;
            x_lo <= rd_wl;
            y_lo <= rd_irr;
          end else begin
            hi   <= mid_r;
            x_hi <= rd_wl;
            y_hi <= rd_irr;
          end
          state <= S_MID;
        end
        S_INTP: begin
          if (x_lo == q) begin
            y     <= y_lo;
            state <= S_SMUL;
          end else if (x_hi == q) begin
            y     <= y_hi;
            state <= S_SMUL;
          end else if (x_hi <= x_lo || q < x_lo) begin
            y     <= y_lo;
            state <= S_SMUL;
          end else begin
            up    <= (y_hi >= y_lo);
            diff  <= (y_hi >= y_lo) ? y_hi - y_lo : y_lo - y_hi;
            num   <= q - x_lo;
            dx    <= x_hi - x_lo;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= product;
          state <= S_PREP;
        end
        S_PREP: begin
          rem   <= {32'd0, prod[63:32]};
          sh    <= prod[31:0];
          dvs   <= {32'd0, dx};
          cnt   <= '0;
          scale <= 1'b0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? 64'(r2 - {1'b0, dvs}) : r2[63:0];
          sh  <= {sh[30:0], 1'b0};
          quo <= quo_next;
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            if (scale) begin
              res     <= quo_next;
              res_val <= 1'b1;
              state   <= S_OUT;
            end else begin
              y     <= up ? y_lo + quo_next : y_lo - quo_next;
              state <= S_SMUL;
            end
          end
        end
        S_SMUL: begin
          prod  <= product;
          state <= S_SCHK;
        end
        S_SCHK: begin
          res_val <= 1'b1;
          if (y == '0) begin
            res   <= '0;
            state <= S_OUT;
          end else if ({16'd0, y, 16'd0} >= prod) begin
            res   <= SAT32;
            state <= S_OUT;
          end else begin
            rem   <= {16'd0, y, 16'd0};
            sh    <= '0;
            dvs   <= prod;
            cnt   <= '0;
            scale <= 1'b1;
            state <= S_DIV;
          end
        end
        S_OUT: begin
          if (!results.valid || results.ready) begin
            results.irradiance_out <= res;
            results.valid_res      <= res_val;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_search_span: assert property (@(posedge clk) disable iff (rst)
    state == S_MIDW |-> ({1'b0, hi} - {1'b0, lo}) > 1)
    else $error("search window too narrow for a probe");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < dvs)
    else $error("divider remainder not below divisor");
  a_probe_return: assert property (@(posedge clk) disable iff (rst)
    state == S_MIDW |=> state == S_MID)
    else $error("probe did not return to search");
`endif
endmodule
